/* rtl/core/etns_pkg.sv */
// shared types, constants and helpers for the euclidean track note scheduler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package etns_pkg;

   localparam logic [1:0] OP_STEP  = 2'd0;
   localparam logic [1:0] OP_TIME  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam int          MAX_RESULTS = 8;
   localparam int          CNT_W       = 4;
   localparam logic [9:0]  LEN_MIN     = 10'd50;
   localparam logic [9:0]  LEN_MAX     = 10'd700;
   // floor(x / 3) == (x * RECIP3) >> 33 for every 32-bit x
   localparam logic [31:0] RECIP3      = 32'hAAAA_AAAB;

   typedef struct packed {
      logic [2:0] res;
      logic [6:0] steps;
      logic [6:0] note;
      logic [6:0] vel;
      logic [3:0] chan;
      logic [9:0] len;
   } params_type;

   typedef struct packed {
      logic [31:0] due;
      logic [6:0]  note;
      logic [3:0]  chan;
      logic [6:0]  vel;
      logic [9:0]  len;
   } off_type;

   typedef struct packed {
      logic       is_on;
      logic [2:0] track;
      logic [3:0] chan;
      logic [6:0] note;
      logic [6:0] vel;
      logic [9:0] len;
      logic       last;
   } event_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [9:0] clamp_len(input logic [9:0] v);
      logic [9:0] r;
      r = v;
      if (v < LEN_MIN) r = LEN_MIN;
      if (v > LEN_MAX) r = LEN_MAX;
      return r;
   endfunction

   // right shift applied to ticks/3: 24, 12, 6, 3 ticks per step
   function automatic logic [1:0] step_shift(input logic [2:0] res);
      logic [1:0] s;
      case (res)
         3'd0, 3'd1: s = 2'd3;
         3'd2:       s = 2'd2;
         3'd3:       s = 2'd1;
         default:    s = 2'd0;
      endcase
      return s;
   endfunction

endpackage

/* rtl/core/etns_if.sv */
// valid/ready channel interfaces for request and response beats
// no dependencies
`timescale 1ns / 1ps

interface etns_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [2:0]  track_index;
   logic [31:0] tick_count;
   logic [31:0] now_ms;
   logic [2:0]  resolution;
   logic [6:0]  step_total;
   logic [63:0] pattern_bits;
   logic [6:0]  note_number;
   logic [6:0]  note_velocity;
   logic [3:0]  midi_channel;
   logic [9:0]  note_length;
   logic        track_enabled;

   modport source (output valid, operation, track_index, tick_count, now_ms, resolution,
                   step_total, pattern_bits, note_number, note_velocity, midi_channel,
                   note_length, track_enabled, input ready);
   modport sink (input valid, operation, track_index, tick_count, now_ms, resolution,
                 step_total, pattern_bits, note_number, note_velocity, midi_channel,
                 note_length, track_enabled, output ready);
endinterface

interface etns_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_note_on;
   logic [2:0] source_track;
   logic [3:0] event_channel;
   logic [6:0] event_note;
   logic [6:0] event_velocity;
   logic [9:0] event_length;
   logic       last_event;

   modport source (output valid, is_note_on, source_track, event_channel, event_note,
                   event_velocity, event_length, last_event, input ready);
   modport sink (input valid, is_note_on, source_track, event_channel, event_note,
                 event_velocity, event_length, last_event, output ready);
endinterface

/* rtl/core/etns_track_mem.sv */
// track table memory: parameter word and pattern word per track
// depends on etns_pkg
`timescale 1ns / 1ps

module etns_track_mem #(
   parameter int TRACK_COUNT = 8,
   parameter int AW = 3
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  etns_pkg::params_type   wr_params,
   input  logic [63:0]            wr_pattern,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output etns_pkg::params_type   rd_params,
   output logic [63:0]            rd_pattern,
   input  logic                   len_rd_en,
   input  logic [AW-1:0]          len_rd_addr,
   output logic [9:0]             len_rd_data
);
   import etns_pkg::*;

   params_type  params_mem  [TRACK_COUNT];
   logic [63:0] pattern_mem [TRACK_COUNT];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         params_mem[wr_addr]  <= wr_params;
         pattern_mem[wr_addr] <= wr_pattern;
      end
      if (rd_en) begin
         rd_params  <= params_mem[rd_addr];
         rd_pattern <= pattern_mem[rd_addr];
      end
      // second read port only looks up the length of the channel's first track
      if (len_rd_en) begin
         len_rd_data <= params_mem[len_rd_addr].len;
      end
   end

endmodule

/* rtl/core/etns_off_mem.sv */
// pending note-off memory: due time and stored event per track
// depends on etns_pkg
`timescale 1ns / 1ps

module etns_off_mem #(
   parameter int TRACK_COUNT = 8,
   parameter int AW = 3
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  etns_pkg::off_type  wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output etns_pkg::off_type  rd_data
);
   import etns_pkg::*;

   off_type off_mem [TRACK_COUNT];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         off_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= off_mem[rd_addr];
      end
   end

endmodule

/* rtl/core/etns_rem_div.sv */
// remainder unit: 32-bit dividend mod 7-bit divisor, four quotient bits a cycle
// depends on etns_pkg
`timescale 1ns / 1ps

module etns_rem_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               dividend,
   input  logic [6:0]                divisor,
   output etns_pkg::div_status_type  status,
   output logic [6:0]                remainder
);
   import etns_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  iter_ff, iter_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  dsr_ff, dsr_in;
   logic [6:0]  r_step;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      r_step  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = 3'd0;
         dvd_in  = dividend;
         rem_in  = 7'd0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // restoring steps, remainder stays below the divisor (at most 63)
         for (int i = 0; i < 4; i++) begin
            r_step = {r_step[5:0], dvd_ff[31 - i]};
            if (r_step >= dsr_ff) r_step = r_step - dsr_ff;
         end
         rem_in  = r_step;
         dvd_in  = {dvd_ff[27:0], 4'd0};
         iter_in = iter_ff + 3'd1;
         if (iter_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

/* rtl/core/euclidean_track_note_scheduler.sv */
// top level of the euclidean track note scheduler: sequencer, flags, output register
// depends on etns_pkg, etns_if, etns_track_mem, etns_off_mem, etns_rem_div
`timescale 1ns / 1ps
//
//  channel  | dir | handshake           | beat
//  ---------+-----+---------------------+------------------------------------------
//  req_if   | in  | valid/ready         | step start, time update or track write
//  rsp_if   | out | valid/ready         | one note-on or note-off, last_event on
//           |     |                     | the final beat of a request
//
//  sequencing: a write or an ignored operation leaves the sequencer idle and ready.
//  a step request keeps ready low while the tracks are walked: an enabled track
//  goes through read, check, remainder (four quotient bits a cycle) and step, a
//  disabled one through read and check. a time request: read, off check per track.
//  reset: synchronous; clears enables, pending note-offs and sets every last
//  step to the sentinel 127. track and note-off memories are undefined until
//  written. stalls: a held event waits on the output register; the walk pauses
//  only when both are full. one request is worked on at a time.

module euclidean_track_note_scheduler #(
   parameter int TRACK_COUNT = 8,
   parameter int MAX_STEPS = 64
) (
   input  logic         clock,
   input  logic         reset,
   etns_req_if.sink     req_if,
   etns_rsp_if.source   rsp_if
);
   import etns_pkg::*;

   localparam int AW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
   localparam int CW = $clog2(TRACK_COUNT + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;
   localparam logic [2:0] S_OFF  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   // sequencer state
   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    t_ff, t_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       op_ff, op_in;
   logic [31:0]      now_ff, now_in;
   logic [63:0]      prod_ff, prod_in;

   // per-track flags in flip-flops
   logic             on_ff      [TRACK_COUNT];
   logic             pend_ff    [TRACK_COUNT];
   logic [6:0]       last_ff    [TRACK_COUNT];
   logic [3:0]       chan_ff    [TRACK_COUNT];

   // held event and output register
   logic             held_valid_ff, held_valid_in;
   event_type        held_ff, held_in;
   logic             rsp_valid_ff, rsp_valid_in;
   event_type        rsp_ff, rsp_in;

   logic [AW-1:0]    t_idx;
   logic             push_ok;
   logic             accept;
   logic             wr_ok;

   // memory and divider hookup
   logic             tm_wr_en, tm_rd_en, len_rd_en;
   logic [AW-1:0]    tm_wr_addr, len_rd_addr;
   params_type       tm_wr_params, rd_params;
   logic [63:0]      rd_pattern;
   logic [9:0]       len_rd_data;
   logic             om_wr_en;
   off_type          om_wr_data, om_rd_data;
   logic             div_start;
   logic [31:0]      div_dividend;
   div_status_type   div_status;
   logic [6:0]       div_rem;

   // flag updates requested by the sequencer
   logic             set_last, set_pend, clr_pend;

   assign t_idx   = t_ff[AW-1:0];
   assign push_ok = !rsp_valid_ff || rsp_if.ready;
   assign accept  = req_if.valid && req_if.ready;
   assign wr_ok   = accept && (req_if.operation == OP_WRITE)
                    && (5'(req_if.track_index) < 5'(TRACK_COUNT));

   assign req_if.ready = (state_ff == S_IDLE);

   // write beat: clamp the length and saturate the step count on the way in
   always_comb begin
      tm_wr_en            = wr_ok;
      tm_wr_addr          = AW'(req_if.track_index);
      tm_wr_params.res    = req_if.resolution;
      tm_wr_params.steps  = (req_if.step_total > 7'(MAX_STEPS)) ? 7'(MAX_STEPS)
                                                                 : req_if.step_total;
      tm_wr_params.note   = req_if.note_number;
      tm_wr_params.vel    = req_if.note_velocity;
      tm_wr_params.chan   = req_if.midi_channel;
      tm_wr_params.len    = clamp_len(req_if.note_length);
   end

   // lowest track sharing the channel; the emitting track itself always matches
   always_comb begin
      len_rd_addr = t_idx;
      for (int j = TRACK_COUNT - 1; j >= 0; j--) begin
         if (chan_ff[j] == rd_params.chan) len_rd_addr = AW'(j);
      end
   end

   assign div_dividend = {1'b0, prod_ff[63:33]} >> step_shift(rd_params.res);

   always_comb begin
      om_wr_data.due  = now_ff + 32'(rd_params.len);
      om_wr_data.note = rd_params.note;
      om_wr_data.chan = rd_params.chan;
      om_wr_data.vel  = rd_params.vel;
      om_wr_data.len  = rd_params.len;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      t_in          = t_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      prod_in       = prod_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_in        = rsp_ff;
      tm_rd_en      = 1'b0;
      len_rd_en     = 1'b0;
      om_wr_en      = 1'b0;
      div_start     = 1'b0;
      set_last      = 1'b0;
      set_pend      = 1'b0;
      clr_pend      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_if.operation == OP_STEP || req_if.operation == OP_TIME)) begin
               op_in    = req_if.operation;
               now_in   = req_if.now_ms;
               prod_in  = 64'(req_if.tick_count) * 64'(RECIP3);
               t_in     = '0;
               cnt_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (t_ff == CW'(TRACK_COUNT) || cnt_ff == CNT_W'(MAX_RESULTS)) begin
               state_in = S_FIN;
            end else begin
               tm_rd_en = 1'b1;
               state_in = (op_ff == OP_STEP) ? S_CHK : S_OFF;
            end
         end
         S_CHK: begin
            if (!on_ff[t_idx] || rd_params.steps == 7'd0) begin
               t_in     = t_ff + CW'(1);
               state_in = S_RD;
            end else begin
               div_start = 1'b1;
               len_rd_en = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) state_in = S_STEP;
         end
         S_STEP: begin
            if (div_rem == last_ff[t_idx]) begin
               t_in     = t_ff + CW'(1);
               state_in = S_RD;
            end else if (!rd_pattern[div_rem[5:0]]) begin
               set_last = 1'b1;
               t_in     = t_ff + CW'(1);
               state_in = S_RD;
            end else if (!held_valid_ff || push_ok) begin
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = held_ff;
                  rsp_in.last  = 1'b0;
               end
               held_valid_in = 1'b1;
               held_in.is_on = 1'b1;
               held_in.track = 3'(t_idx);
               held_in.chan  = rd_params.chan;
               held_in.note  = rd_params.note;
               held_in.vel   = rd_params.vel;
               held_in.len   = clamp_len(len_rd_data);
               held_in.last  = 1'b0;
               om_wr_en      = 1'b1;
               set_last      = 1'b1;
               set_pend      = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
               t_in          = t_ff + CW'(1);
               state_in      = S_RD;
            end
         end
         S_OFF: begin
            if (!pend_ff[t_idx] || now_ff < om_rd_data.due) begin
               t_in     = t_ff + CW'(1);
               state_in = S_RD;
            end else if (!held_valid_ff || push_ok) begin
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = held_ff;
                  rsp_in.last  = 1'b0;
               end
               held_valid_in = 1'b1;
               held_in.is_on = 1'b0;
               held_in.track = 3'(t_idx);
               held_in.chan  = om_rd_data.chan;
               held_in.note  = om_rd_data.note;
               held_in.vel   = om_rd_data.vel;
               held_in.len   = clamp_len(om_rd_data.len);
               held_in.last  = 1'b0;
               clr_pend      = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
               t_in          = t_ff + CW'(1);
               state_in      = S_RD;
            end
         end
         S_FIN: begin
            // the held event is the final one of this request
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (push_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = held_ff;
               rsp_in.last   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         t_ff          <= '0;
         cnt_ff        <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < TRACK_COUNT; i++) begin
            on_ff[i]   <= 1'b0;
            pend_ff[i] <= 1'b0;
            last_ff[i] <= 7'd127;
         end
      end else begin
         state_ff      <= state_in;
         t_ff          <= t_in;
         cnt_ff        <= cnt_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_ok) on_ff[tm_wr_addr] <= req_if.track_enabled;
         if (set_last) last_ff[t_idx] <= div_rem;
         if (set_pend) pend_ff[t_idx] <= 1'b1;
         if (clr_pend) pend_ff[t_idx] <= 1'b0;
      end
      if (wr_ok) chan_ff[tm_wr_addr] <= req_if.midi_channel;
      op_ff   <= op_in;
      now_ff  <= now_in;
      prod_ff <= prod_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

   etns_track_mem #(.TRACK_COUNT(TRACK_COUNT), .AW(AW)) u_track_mem (
      .clock       (clock),
      .wr_en       (tm_wr_en),
      .wr_addr     (tm_wr_addr),
      .wr_params   (tm_wr_params),
      .wr_pattern  (req_if.pattern_bits),
      .rd_en       (tm_rd_en),
      .rd_addr     (t_idx),
      .rd_params   (rd_params),
      .rd_pattern  (rd_pattern),
      .len_rd_en   (len_rd_en),
      .len_rd_addr (len_rd_addr),
      .len_rd_data (len_rd_data)
   );

   etns_off_mem #(.TRACK_COUNT(TRACK_COUNT), .AW(AW)) u_off_mem (
      .clock   (clock),
      .wr_en   (om_wr_en),
      .wr_addr (t_idx),
      .wr_data (om_wr_data),
      .rd_en   (tm_rd_en),
      .rd_addr (t_idx),
      .rd_data (om_rd_data)
   );

   etns_rem_div u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (rd_params.steps),
      .status    (div_status),
      .remainder (div_rem)
   );

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.is_note_on     = rsp_ff.is_on;
   assign rsp_if.source_track   = rsp_ff.track;
   assign rsp_if.event_channel  = rsp_ff.chan;
   assign rsp_if.event_note     = rsp_ff.note;
   assign rsp_if.event_velocity = rsp_ff.vel;
   assign rsp_if.event_length   = rsp_ff.len;
   assign rsp_if.last_event     = rsp_ff.last;

   // no event may be left behind when a new request is taken
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !held_valid_ff)
      else $error("held event present while accepting a request");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("event count above limit");

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !held_valid_ff) |=> state_ff == S_IDLE)
      else $error("finish did not return to idle");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_status.busy || div_status.done))
      else $error("waiting on a remainder unit that is not running");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.len >= LEN_MIN && rsp_ff.len <= LEN_MAX))
      else $error("event length outside clamp range");

endmodule

/* verif/tb_top.sv */
// self-checking bench for the euclidean track note scheduler
// depends on etns_pkg, etns_if and the scheduler top level under rtl/core
`timescale 1ns / 1ps

module tb_top;
   import etns_pkg::*;

   localparam int TRACKS = 8;
   localparam int STEP_LIMIT = 64;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [6:0] NO_STEP_YET = 7'd127;

   // one request beat as the bench sees it
   typedef struct {
      logic [1:0]  op;
      logic [2:0]  idx;
      logic [31:0] ticks;
      logic [31:0] ms;
      logic [2:0]  res;
      logic [6:0]  steps;
      logic [63:0] pattern;
      logic [6:0]  note;
      logic [6:0]  vel;
      logic [3:0]  chan;
      logic [9:0]  len;
      logic        en;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   etns_req_if req_if ();
   etns_rsp_if rsp_if ();

   euclidean_track_note_scheduler dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   always #5 clock = ~clock;

   // bench copy of the track table and pending note-offs
   logic [63:0] trk_pattern [TRACKS];
   params_type  trk_params  [TRACKS];
   logic        trk_on      [TRACKS];
   logic [6:0]  trk_last    [TRACKS];
   logic        off_armed   [TRACKS];
   off_type     off_entry   [TRACKS];

   event_type pending_events[$];

   int mismatches   = 0;
   int events_seen  = 0;
   int note_ons     = 0;
   int note_offs    = 0;
   int beats_sent   = 0;

   // sender pacing: bursts of random length with random gaps
   int burst_left = 0;
   logic [31:0] tick_now;
   logic [31:0] ms_now;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // --- predictor -----------------------------------------------------------

   function automatic logic [9:0] len_bound(input logic [9:0] v);
      logic [9:0] r;
      r = v;
      if (v < 10'd50) r = 10'd50;
      if (v > 10'd700) r = 10'd700;
      return r;
   endfunction

   // works out the events that one accepted beat causes and updates the copy
   task automatic predict_events(input request_type rq);
      event_type ev;
      event_type batch[$];
      logic [2:0]  rcode;
      logic [31:0] divisor;
      logic [31:0] step_idx;
      logic [9:0]  on_len;
      logic [6:0]  st;
      batch = {};
      case (rq.op)
         OP_WRITE: begin
            st = (rq.steps > STEP_LIMIT) ? 7'(STEP_LIMIT) : rq.steps;
            trk_params[rq.idx] = '{res: rq.res, steps: st, note: rq.note, vel: rq.vel,
                                   chan: rq.chan, len: len_bound(rq.len)};
            trk_pattern[rq.idx] = rq.pattern;
            trk_on[rq.idx] = rq.en;
         end
         OP_STEP: begin
            for (int t = 0; t < TRACKS && batch.size() < MAX_RESULTS; t++) begin
               if (!trk_on[t] || trk_params[t].steps == 0) continue;
               rcode = trk_params[t].res;
               if (rcode < 3'd1) rcode = 3'd1;
               if (rcode > 3'd4) rcode = 3'd4;
               case (rcode)
                  3'd1: divisor = 24;
                  3'd2: divisor = 12;
                  3'd3: divisor = 6;
                  default: divisor = 3;
               endcase
               step_idx = (rq.ticks / divisor) % 32'(trk_params[t].steps);
               if (step_idx == 32'(trk_last[t])) continue;
               trk_last[t] = step_idx[6:0];
               if (!trk_pattern[t][step_idx[5:0]]) continue;
               // length reported is that of the first track sharing the channel
               on_len = 10'd100;
               for (int j = 0; j < TRACKS; j++) begin
                  if (trk_params[j].chan == trk_params[t].chan) begin
                     on_len = trk_params[j].len;
                     break;
                  end
               end
               ev = '{is_on: 1'b1, track: 3'(t), chan: trk_params[t].chan,
                      note: trk_params[t].note, vel: trk_params[t].vel,
                      len: len_bound(on_len), last: 1'b0};
               batch.push_back(ev);
               // new note-on replaces whatever note-off was waiting
               off_armed[t] = 1'b1;
               off_entry[t] = '{due: rq.ms + 32'(len_bound(trk_params[t].len)),
                                note: trk_params[t].note, chan: trk_params[t].chan,
                                vel: trk_params[t].vel, len: len_bound(trk_params[t].len)};
            end
         end
         OP_TIME: begin
            for (int t = 0; t < TRACKS && batch.size() < MAX_RESULTS; t++) begin
               // plain unsigned compare, wrap not handled
               if (off_armed[t] && rq.ms >= off_entry[t].due) begin
                  off_armed[t] = 1'b0;
                  ev = '{is_on: 1'b0, track: 3'(t), chan: off_entry[t].chan,
                         note: off_entry[t].note, vel: off_entry[t].vel,
                         len: off_entry[t].len, last: 1'b0};
                  batch.push_back(ev);
               end
            end
         end
         default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) pending_events.push_back(batch[k]);
   endtask

   // --- sender --------------------------------------------------------------

   // drives one beat, waits for acceptance; valid stays high for a following beat in the same burst
   task automatic send_beat(input request_type rq);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.operation     <= rq.op;
      req_if.track_index   <= rq.idx;
      req_if.tick_count    <= rq.ticks;
      req_if.now_ms        <= rq.ms;
      req_if.resolution    <= rq.res;
      req_if.step_total    <= rq.steps;
      req_if.pattern_bits  <= rq.pattern;
      req_if.note_number   <= rq.note;
      req_if.note_velocity <= rq.vel;
      req_if.midi_channel  <= rq.chan;
      req_if.note_length   <= rq.len;
      req_if.track_enabled <= rq.en;
      do @(posedge clock); while (!req_if.ready);
      predict_events(rq);
      beats_sent++;
   endtask

   function automatic request_type random_request(input logic [1:0] op);
      request_type rq;
      rq.op      = op;
      rq.idx     = 3'($urandom_range(0, 7));
      rq.ticks   = tick_now;
      rq.ms      = ms_now;
      rq.res     = 3'($urandom_range(0, 7));
      rq.steps   = 7'($urandom_range(0, 127));
      rq.pattern = {$urandom, $urandom};
      rq.note    = 7'($urandom);
      rq.vel     = 7'($urandom);
      rq.chan    = 4'($urandom);
      rq.len     = 10'($urandom);
      rq.en      = 1'($urandom);
      return rq;
   endfunction

   task automatic write_track(input logic [2:0] idx, input logic [2:0] res,
                              input logic [6:0] steps, input logic [63:0] pattern,
                              input logic [3:0] chan, input logic [9:0] len,
                              input logic en);
      request_type rq;
      rq = random_request(OP_WRITE);
      rq.idx = idx;
      rq.res = res;
      rq.steps = steps;
      rq.pattern = pattern;
      rq.chan = chan;
      rq.len = len;
      rq.en = en;
      send_beat(rq);
   endtask

   task automatic step_at(input logic [31:0] ticks, input logic [31:0] ms);
      tick_now = ticks;
      ms_now = ms;
      send_beat(random_request(OP_STEP));
   endtask

   task automatic time_at(input logic [31:0] ms);
      ms_now = ms;
      send_beat(random_request(OP_TIME));
   endtask

   // --- tests ---------------------------------------------------------------

   // every entry written first so no step ever reads an empty entry
   task automatic test_table_load;
      write_track(3'd0, 3'd1, 7'd1,   64'h1,                 4'd0,  10'd0,    1'b1);
      write_track(3'd1, 3'd2, 7'd64,  64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 10'd1023, 1'b1);
      write_track(3'd2, 3'd0, 7'd100, 64'hAAAA_5555_0F0F_F0F0, 4'd0,  10'd300,  1'b1);
      write_track(3'd3, 3'd5, 7'd16,  64'h0,                 4'd7,  10'd49,   1'b1);
      write_track(3'd4, 3'd7, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 4'd7,  10'd700,  1'b1);
      write_track(3'd5, 3'd4, 7'd8,   64'h55,                4'd15, 10'd50,   1'b0);
      write_track(3'd6, 3'd3, 7'd127, 64'h8000_0000_0000_0001, 4'd3,  10'd701,  1'b1);
      write_track(3'd7, 3'd6, 7'd3,   64'h7,                 4'd9,  10'd512,  1'b1);
   endtask

   task automatic test_step_and_off;
      step_at(32'd0, 32'd1000);
      step_at(32'd0, 32'd1001);          // same step again, no new notes
      step_at(32'd24, 32'd1010);
      time_at(32'd1049);
      time_at(32'd1100);
      time_at(32'd1800);
      step_at(32'hFFFF_FFFF, 32'hFFFF_FF00); // due time wraps past zero
      time_at(32'hFFFF_FFFF);
      time_at(32'd500);
   endtask

   task automatic test_odd_cases;
      send_beat(random_request(OP_IGNORED));
      // all eight tracks on one pattern, full result count in both directions
      for (int t = 0; t < TRACKS; t++)
         write_track(3'(t), 3'(t), 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 4'(t % 3), 10'(t * 130),
                     1'b1);
      step_at(32'd3000, 32'd5000);
      step_at(32'd3003, 32'd5001);
      time_at(32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic;
      int r;
      int sent;
      sent = 0;
      while (sent < 90) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 15) == 0) tick_now = $urandom;
         else tick_now += $urandom_range(0, 30);
         if ($urandom_range(0, 25) == 0) ms_now = $urandom;
         else if ($urandom_range(0, 40) == 0) ms_now = 32'hFFFF_FFFF - $urandom_range(0, 800);
         else ms_now += $urandom_range(0, 300);
         if (r < 15) send_beat(random_request(OP_WRITE));
         else if (r < 60) send_beat(random_request(OP_STEP));
         else if (r < 95) send_beat(random_request(OP_TIME));
         else begin
            send_beat(random_request(OP_IGNORED));
            continue;
         end
         sent++;
      end
   endtask

   // --- result checker and receiver stall pattern ---------------------------

   int stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         events_seen++;
         if (rsp_if.is_note_on) note_ons++;
         else note_offs++;
         if (pending_events.size() == 0) begin
            report_mismatch("events waiting, unexpected event", 32'd0, 32'd1);
         end else begin
            want = pending_events.pop_front();
            if (rsp_if.is_note_on !== want.is_on)
               report_mismatch("is_note_on", 32'(rsp_if.is_note_on), 32'(want.is_on));
            if (rsp_if.source_track !== want.track)
               report_mismatch("source_track", 32'(rsp_if.source_track), 32'(want.track));
            if (rsp_if.event_channel !== want.chan)
               report_mismatch("event_channel", 32'(rsp_if.event_channel), 32'(want.chan));
            if (rsp_if.event_note !== want.note)
               report_mismatch("event_note", 32'(rsp_if.event_note), 32'(want.note));
            if (rsp_if.event_velocity !== want.vel)
               report_mismatch("event_velocity", 32'(rsp_if.event_velocity), 32'(want.vel));
            if (rsp_if.event_length !== want.len)
               report_mismatch("event_length", 32'(rsp_if.event_length), 32'(want.len));
            if (rsp_if.last_event !== want.last)
               report_mismatch("last_event", 32'(rsp_if.last_event), 32'(want.last));
         end
      end
   end

   // --- main sequence -------------------------------------------------------

   initial begin
      req_if.valid <= 1'b0;
      req_if.operation <= OP_IGNORED;
      req_if.track_index <= '0;
      req_if.tick_count <= '0;
      req_if.now_ms <= '0;
      req_if.resolution <= '0;
      req_if.step_total <= '0;
      req_if.pattern_bits <= '0;
      req_if.note_number <= '0;
      req_if.note_velocity <= '0;
      req_if.midi_channel <= '0;
      req_if.note_length <= '0;
      req_if.track_enabled <= 1'b0;
      tick_now = '0;
      ms_now = '0;
      for (int t = 0; t < TRACKS; t++) begin
         trk_on[t] = 1'b0;
         trk_last[t] = NO_STEP_YET;
         off_armed[t] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_step_and_off();
      test_odd_cases();
      test_random_traffic();

      req_if.valid <= 1'b0;
      wait (pending_events.size() == 0);
      repeat (200) @(posedge clock);

      $display("covered %0d request beats: table writes, steps, time updates, ignored ops",
               beats_sent);
      $display("checked %0d events (%0d note-on, %0d note-off)", events_seen, note_ons,
               note_offs);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout with %0d events still expected", pending_events.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
